/* design/rpip_pkg.sv */
package rpip_pkg;

   localparam int VALUE_BITS = 64;
   localparam int OUT_BITS = 64;
   localparam int RADIX_BITS = 5;
   localparam int CHAR_BITS = 8;

   localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_BITS'(10);
   localparam logic [RADIX_BITS-1:0] RADIX_HEX = RADIX_BITS'(16);
   localparam logic [RADIX_BITS-1:0] RADIX_BIN = RADIX_BITS'(2);
   localparam logic [RADIX_BITS-1:0] RADIX_DEC = RADIX_BITS'(10);
   localparam logic [RADIX_BITS-1:0] RADIX_OCT = RADIX_BITS'(8);

   typedef enum logic [4:0] {
      SCAN_BEGIN  = 5'b00001,
      SCAN_SIGN   = 5'b00010,
      SCAN_ZERO   = 5'b00100,
      SCAN_RADIX  = 5'b01000,
      SCAN_DIGITS = 5'b10000
   } scan_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } digit_type;

   function automatic digit_type digit_of(input logic [CHAR_BITS-1:0] ch,
                                          input logic [RADIX_BITS-1:0] radix);
      digit_type d;
      d.ok = 1'b1;
      d.val = 4'd0;
      if (ch inside {["0":"9"]}) begin
         d.val = 4'(ch - "0");
      end else if (ch inside {["a":"f"]}) begin
         d.val = 4'(ch - "a" + 8'd10);
      end else if (ch inside {["A":"F"]}) begin
         d.val = 4'(ch - "A" + 8'd10);
      end else begin
         d.ok = 1'b0;
      end
      if ({1'b0, d.val} >= radix) begin
         d.ok = 1'b0;
      end
      return d;
   endfunction

endpackage

/* design/radix_prefixed_integer_parser.sv */
// channel   ports                                   direction
// req       req_valid req_stall req_char_code       in, one byte of a word
//           req_last_char
// rsp       rsp_valid rsp_stall rsp_value           out, one per word
//           rsp_is_number
// csr       csr_write_enable csr_write_data         in, default radix
//
// one byte per cycle unless stalled: each accepted byte updates the scan
// state through one decode and a multiply-add of the accumulator by the radix
// (at most 5 bits). the last byte of a word loads the result register in the
// same cycle. reset is synchronous: scan state begin, default radix 10, no
// result held. req_stall is high while a result is held and rsp_stall is high.
module radix_prefixed_integer_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rpip_pkg::CHAR_BITS-1:0]      req_char_code,
   input  logic                                req_last_char,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [rpip_pkg::OUT_BITS-1:0] rsp_value,
   output logic                                rsp_is_number,
   input  logic                                csr_write_enable,
   input  logic [rpip_pkg::RADIX_BITS-1:0]     csr_write_data
);
   import rpip_pkg::*;

   logic [RADIX_BITS-1:0] default_radix_ff, default_radix_in;
   scan_type              scan_ff, scan_in;
   logic                  negative_ff, negative_in;
   logic [RADIX_BITS-1:0] radix_ff, radix_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic                  invalid_ff, invalid_in;
   logic                  started_ff, started_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_BITS-1:0] value_ff, value_in;
   logic                  is_number_ff, is_number_in;

   logic                  accept;
   digit_type             dig;
   logic [VALUE_BITS-1:0] mac;
   logic [VALUE_BITS-1:0] signed_val;
   logic                  take;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept = req_valid & ~req_stall;

   assign dig = digit_of(req_char_code, radix_ff);
   assign mac = VALUE_BITS'(acc_ff * VALUE_BITS'(radix_ff)) + VALUE_BITS'(dig.val);

   always_comb begin
      scan_in = scan_ff;
      negative_in = negative_ff;
      radix_in = radix_ff;
      acc_in = acc_ff;
      invalid_in = invalid_ff;
      started_in = started_ff;
      default_radix_in = default_radix_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      value_in = value_ff;
      is_number_in = is_number_ff;
      take = 1'b0;
      signed_val = '0;

      if (csr_write_enable) begin
         default_radix_in = csr_write_data;
         if (!started_ff) begin
            radix_in = csr_write_data;
         end
      end

      if (accept) begin
         started_in = 1'b1;
         if (!invalid_ff) begin
            case (scan_ff)
               SCAN_BEGIN, SCAN_SIGN: begin
                  if (scan_ff == SCAN_BEGIN && (req_char_code == "+" ||
                                                req_char_code == "-")) begin
                     negative_in = (req_char_code == "-");
                     scan_in = SCAN_SIGN;
                  end else if (req_char_code == "0") begin
                     scan_in = SCAN_ZERO;
                  end else if (dig.ok) begin
                     take = 1'b1;
                  end else begin
                     invalid_in = 1'b1;
                  end
               end
               SCAN_ZERO: begin
                  if (req_char_code == "x" || req_char_code == "X") begin
                     radix_in = RADIX_HEX;
                     scan_in = SCAN_RADIX;
                  end else if (req_char_code == "b" || req_char_code == "B") begin
                     radix_in = RADIX_BIN;
                     scan_in = SCAN_RADIX;
                  end else if (req_char_code == "d" || req_char_code == "D") begin
                     radix_in = RADIX_DEC;
                     scan_in = SCAN_RADIX;
                  end else if (req_char_code == "o" || req_char_code == "O") begin
                     radix_in = RADIX_OCT;
                     scan_in = SCAN_RADIX;
                  end else if (dig.ok) begin
                     take = 1'b1;
                  end else begin
                     invalid_in = 1'b1;
                  end
               end
               SCAN_RADIX, SCAN_DIGITS: begin
                  if (dig.ok) begin
                     take = 1'b1;
                  end else begin
                     invalid_in = 1'b1;
                  end
               end
               default: begin
                  invalid_in = 1'b1;
               end
            endcase
            if (take) begin
               acc_in = mac;
               scan_in = SCAN_DIGITS;
            end
         end

         if (req_last_char) begin
            // end of word: emit result and start over
            signed_val = negative_in ? VALUE_BITS'(-acc_in) : acc_in;
            rsp_valid_in = 1'b1;
            is_number_in = ~invalid_in;
            value_in = invalid_in ? '0 : OUT_BITS'(signed'(signed_val));
            scan_in = SCAN_BEGIN;
            negative_in = 1'b0;
            radix_in = default_radix_in;
            acc_in = '0;
            invalid_in = 1'b0;
            started_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_radix_ff <= RADIX_RESET;
         scan_ff <= SCAN_BEGIN;
         negative_ff <= 1'b0;
         radix_ff <= RADIX_RESET;
         acc_ff <= '0;
         invalid_ff <= 1'b0;
         started_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         default_radix_ff <= default_radix_in;
         scan_ff <= scan_in;
         negative_ff <= negative_in;
         radix_ff <= radix_in;
         acc_ff <= acc_in;
         invalid_ff <= invalid_in;
         started_ff <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      is_number_ff <= is_number_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = value_ff;
   assign rsp_is_number = is_number_ff;

endmodule
